// File: hw/rtl/tmhq_pkg.sv
// Package for the timer heap queue: action and status codes, field widths,
// front-to-back command type. No dependencies.
`default_nettype none
package tmhq_pkg;
  localparam int unsigned ActionW  = 3;
  localparam int unsigned FdW      = 8;
  localparam int unsigned TimeoutW = 24;
  localparam int unsigned ElapsedW = 16;
  localparam int unsigned WaitW    = 25;
  localparam int unsigned ClockW   = 32;

  typedef enum logic [2:0] {
    ACT_ADD    = 3'd0,
    ACT_REARM  = 3'd1,
    ACT_FIRE   = 3'd2,
    ACT_ADV    = 3'd3,
    ACT_CLEAR  = 3'd4,
    ACT_NOP5   = 3'd5,
    ACT_NOP6   = 3'd6,
    ACT_NOP7   = 3'd7
  } action_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ABSENT = 2'd1,
    ST_FULL   = 2'd2,
    ST_RANGE  = 2'd3
  } status_e;

  typedef struct packed {
    action_e                action;
    logic [FdW-1:0]         fd;
    logic [TimeoutW-1:0]    timeout_ms;
    logic [ElapsedW-1:0]    elapsed_ms;
    logic                   range_err;
  } cmd_t;

  // true when a is strictly before b, wrap-aware
  function automatic logic earlier(input logic [ClockW-1:0] a, input logic [ClockW-1:0] b);
    logic [ClockW-1:0] d;
    d = a - b;
    return d[ClockW-1];
  endfunction
endpackage
`default_nettype wire

// File: hw/rtl/tmhq_if.sv
// Valid/ready channel interfaces for the timer heap queue.
// Depends on tmhq_pkg.
`default_nettype none
interface tmhq_in_if;
  logic                            valid;
  logic                            ready;
  logic [2:0]                      action;
  logic [tmhq_pkg::FdW-1:0]        fd;
  logic [tmhq_pkg::TimeoutW-1:0]   timeout_ms;
  logic [tmhq_pkg::ElapsedW-1:0]   elapsed_ms;
  modport source (output valid, action, fd, timeout_ms, elapsed_ms, input ready);
  modport sink (input valid, action, fd, timeout_ms, elapsed_ms, output ready);
endinterface

interface tmhq_out_if;
  logic                              valid;
  logic                              ready;
  logic                              fired;
  logic [tmhq_pkg::FdW-1:0]          fired_fd;
  logic [1:0]                        status;
  logic signed [tmhq_pkg::WaitW-1:0] next_wait_ms;
  logic                              last;
  modport source (output valid, fired, fired_fd, status, next_wait_ms, last, input ready);
  modport sink (input valid, fired, fired_fd, status, next_wait_ms, last, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/tmhq_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module tmhq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// File: hw/rtl/tmhq_front.sv
// Front end: accepts input items, range-checks the fd, and pushes commands
// into a two-entry queue for the back end. Depends on tmhq_pkg, tmhq_if.
`default_nettype none
module tmhq_front #(
  parameter int unsigned FdSlots = 256
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  tmhq_in_if.sink            in_if,
  output logic               cmd_valid_o,
  output tmhq_pkg::cmd_t     cmd_o,
  input  wire logic          cmd_pop_i
);
  tmhq_pkg::cmd_t q_q [2];
  logic [1:0]     cnt_q, cnt_d;
  logic           rd_q, wr_q;
  logic           push;
  tmhq_pkg::cmd_t c;

  assign in_if.ready = (cnt_q != 2'd2);
  assign push        = in_if.valid && in_if.ready;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_q[rd_q];

  always_comb begin
    c.action     = tmhq_pkg::action_e'(in_if.action);
    c.fd         = in_if.fd;
    c.timeout_ms = in_if.timeout_ms;
    c.elapsed_ms = in_if.elapsed_ms;
    c.range_err  = (in_if.action <= 3'd2) &&
                   ({1'b0, in_if.fd} >= (tmhq_pkg::FdW+1)'(FdSlots > 256 ? 256 : FdSlots));
    cnt_d = cnt_q + 2'(push) - 2'(cmd_pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push) q_q[wr_q] <= c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_q <= ~wr_q;
      if (cmd_pop_i) rd_q <= ~rd_q;
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/tmhq_back.sv
// Back end: heap sequencer over expiry/owner registers and the fd slot map RAM,
// emits fired items and the closing status. Depends on tmhq_pkg, tmhq_if, tmhq_ram.
`default_nettype none
module tmhq_back #(
  parameter int unsigned Capacity = 32,
  parameter int unsigned FdSlots  = 256
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_valid_i,
  input  tmhq_pkg::cmd_t     cmd_i,
  output logic               cmd_pop_o,
  tmhq_out_if.source         out_if
);
  localparam int unsigned SW = $clog2(Capacity);
  localparam int unsigned CW = $clog2(Capacity + 1);
  localparam int unsigned FW = tmhq_pkg::FdW;
  localparam int unsigned XW = tmhq_pkg::ClockW;
  localparam int unsigned MD = (FdSlots > 256) ? 256 : FdSlots;
  localparam int unsigned AW = $clog2(MD);
  localparam logic [XW-1:0] WaitSat = XW'(16777215);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_WAIT  = 4'd1;
  localparam logic [3:0] S_DISP  = 4'd2;
  localparam logic [3:0] S_DOWN  = 4'd3;
  localparam logic [3:0] S_UP    = 4'd4;
  localparam logic [3:0] S_FIX   = 4'd5;
  localparam logic [3:0] S_ADVCK = 4'd6;
  localparam logic [3:0] S_EMIT  = 4'd7;
  localparam logic [3:0] S_RMV   = 4'd8;
  localparam logic [3:0] S_CLR   = 4'd9;
  localparam logic [3:0] S_STAT  = 4'd10;

  // heap entries are registers: sifting compares a node with its children
  // or its parent in the same cycle
  logic [XW-1:0] exp_q [Capacity];
  logic [FW-1:0] own_q [Capacity];
  logic [CW-1:0] cnt_q;
  logic [XW-1:0] now_q;
  logic [MD-1:0] vld_q;

  logic [3:0]        st_q, ret_q;
  tmhq_pkg::cmd_t    cmd_q;
  logic [SW-1:0]     i_q;
  logic              moved_q;
  tmhq_pkg::status_e sts_q;
  logic [CW-1:0]     ci_q;
  logic [FW-1:0]     pend_fd_q;
  logic [FW-1:0]     hold_fd_q;  // second slot-map write of a swap
  logic [SW-1:0]     hold_sl_q;

  logic              ovld_q;
  logic              ofired_q;
  logic [FW-1:0]     ofd_q;
  logic [1:0]        osts_q;
  logic signed [tmhq_pkg::WaitW-1:0] owait_q;
  logic              olast_q;

  // slot map memory
  logic          map_we;
  logic [AW-1:0] map_wa, map_ra;
  logic [SW-1:0] map_wd, map_rd;

  tmhq_ram #(.Width(SW), .Depth(MD)) u_map (
    .clk_i  (clk_i),
    .we_i   (map_we),
    .waddr_i(map_wa),
    .wdata_i(map_wd),
    .raddr_i(map_ra),
    .rdata_o(map_rd)
  );

  assign out_if.valid        = ovld_q;
  assign out_if.fired        = ofired_q;
  assign out_if.fired_fd     = ofd_q;
  assign out_if.status       = osts_q;
  assign out_if.next_wait_ms = owait_q;
  assign out_if.last         = olast_q;

  logic out_free;
  logic out_load;
  assign out_free = !ovld_q || out_if.ready;
  assign out_load = out_free && ((st_q == S_EMIT) || (st_q == S_STAT) ||
                                 ((st_q == S_CLR) && (ci_q != cnt_q)));

  // child/parent indices
  logic [SW+1:0] c1, c2;
  logic [SW-1:0] par, cs, last_sl;
  logic          down_go, up_go;
  logic          has1, has2;
  logic [3:0]    done_st;
  assign c1      = {1'b0, i_q, 1'b1};
  assign c2      = c1 + (SW+2)'(1);
  assign has1    = c1 < (SW+2)'(cnt_q);
  assign has2    = c2 < (SW+2)'(cnt_q);
  assign par     = (i_q - SW'(1)) >> 1;
  assign last_sl = SW'(cnt_q - CW'(1));
  assign done_st = (cmd_q.action == tmhq_pkg::ACT_ADV) ? S_ADVCK : S_STAT;

  always_comb begin
    cs = c1[SW-1:0];
    if (has2 && tmhq_pkg::earlier(exp_q[c2[SW-1:0]], exp_q[c1[SW-1:0]])) cs = c2[SW-1:0];
    down_go = has1 && !tmhq_pkg::earlier(exp_q[i_q], exp_q[cs]);
    up_go   = (i_q != '0) && !tmhq_pkg::earlier(exp_q[par], exp_q[i_q]);
  end

  // closing wait
  logic [XW-1:0] dwait;
  logic signed [tmhq_pkg::WaitW-1:0] wait_v;
  always_comb begin
    dwait = exp_q[0] - now_q;
    if (cnt_q == '0) wait_v = '1;
    else if (dwait[XW-1]) wait_v = '0;
    else if (dwait > WaitSat) wait_v = tmhq_pkg::WaitW'(WaitSat);
    else wait_v = tmhq_pkg::WaitW'(dwait);
  end

  logic fd_vld;
  logic ins_go;
  assign fd_vld = vld_q[AW'(cmd_q.fd)];
  assign ins_go = !cmd_q.range_err && (cmd_q.action == tmhq_pkg::ACT_ADD) && !fd_vld &&
                  (cnt_q < CW'(Capacity));

  // slot-map writes: a new entry's slot, the entry moved into slot i_q, or the held half of a swap
  always_comb begin
    map_we = 1'b0;
    map_wa = '0;
    map_wd = '0;
    map_ra = AW'(cmd_q.fd);
    unique case (st_q)
      S_DISP: begin
        if (ins_go) begin
          map_we = 1'b1; map_wa = AW'(cmd_q.fd); map_wd = SW'(cnt_q);
        end
      end
      S_DOWN: begin
        if (down_go) begin
          map_we = 1'b1; map_wa = AW'(own_q[cs]); map_wd = i_q;
        end
      end
      S_UP: begin
        if (up_go) begin
          map_we = 1'b1; map_wa = AW'(own_q[par]); map_wd = i_q;
        end
      end
      S_FIX: begin
        map_we = 1'b1; map_wa = AW'(hold_fd_q); map_wd = hold_sl_q;
      end
      S_RMV: begin
        if (i_q < last_sl) begin
          map_we = 1'b1; map_wa = AW'(own_q[last_sl]); map_wd = i_q;
        end
      end
      default: ;
    endcase
  end

  assign cmd_pop_o = (st_q == S_IDLE) && cmd_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q   <= 1'b0;
      ofired_q <= 1'b0;
      ofd_q    <= '0;
      osts_q   <= '0;
      owait_q  <= '0;
      olast_q  <= 1'b0;
    end else if (out_load) begin
      ovld_q   <= 1'b1;
      ofired_q <= (st_q != S_STAT);
      ofd_q    <= (st_q == S_EMIT) ? pend_fd_q : (st_q == S_CLR) ? own_q[SW'(ci_q)] : '0;
      osts_q   <= (st_q == S_STAT) ? sts_q : tmhq_pkg::ST_OK;
      owait_q  <= (st_q == S_STAT) ? wait_v : '0;
      olast_q  <= (st_q == S_STAT);
    end else if (out_if.ready) begin
      ovld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= S_IDLE;
      ret_q     <= S_IDLE;
      cnt_q     <= '0;
      now_q     <= '0;
      vld_q     <= '0;
      cmd_q     <= '0;
      i_q       <= '0;
      moved_q   <= 1'b0;
      sts_q     <= tmhq_pkg::ST_OK;
      ci_q      <= '0;
      pend_fd_q <= '0;
      hold_fd_q <= '0;
      hold_sl_q <= '0;
      for (int unsigned k = 0; k < Capacity; k++) begin
        exp_q[k] <= '0;
        own_q[k] <= '0;
      end
    end else begin
      unique case (st_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            cmd_q <= cmd_i;
            sts_q <= tmhq_pkg::ST_OK;
            st_q  <= S_WAIT;
          end
        end
        S_WAIT: st_q <= S_DISP;  // slot-map read lands
        S_DISP: begin
          if (cmd_q.range_err) begin
            sts_q <= tmhq_pkg::ST_RANGE;
            st_q  <= S_STAT;
          end else begin
            unique case (cmd_q.action)
              tmhq_pkg::ACT_ADD, tmhq_pkg::ACT_REARM: begin
                if (fd_vld) begin
                  exp_q[map_rd] <= now_q + XW'(cmd_q.timeout_ms);
                  i_q <= map_rd; moved_q <= 1'b0;
                  st_q <= S_DOWN;
                end else if (cmd_q.action == tmhq_pkg::ACT_REARM) begin
                  sts_q <= tmhq_pkg::ST_ABSENT; st_q <= S_STAT;
                end else if (cnt_q >= CW'(Capacity)) begin
                  sts_q <= tmhq_pkg::ST_FULL; st_q <= S_STAT;
                end else begin
                  exp_q[SW'(cnt_q)] <= now_q + XW'(cmd_q.timeout_ms);
                  own_q[SW'(cnt_q)] <= cmd_q.fd;
                  vld_q[AW'(cmd_q.fd)] <= 1'b1;
                  cnt_q <= cnt_q + CW'(1);
                  i_q <= SW'(cnt_q);
                  st_q <= S_UP;
                end
              end
              tmhq_pkg::ACT_FIRE: begin
                if (!fd_vld || cnt_q == '0) begin
                  sts_q <= tmhq_pkg::ST_ABSENT; st_q <= S_STAT;
                end else begin
                  pend_fd_q <= cmd_q.fd; i_q <= map_rd;
                  st_q <= S_EMIT;
                end
              end
              tmhq_pkg::ACT_ADV: begin
                now_q <= now_q + XW'(cmd_q.elapsed_ms);
                st_q  <= S_ADVCK;
              end
              tmhq_pkg::ACT_CLEAR: begin
                ci_q <= '0; st_q <= S_CLR;
              end
              default: st_q <= S_STAT;
            endcase
          end
        end
        S_ADVCK: begin
          if (cnt_q != '0 && !tmhq_pkg::earlier(now_q, exp_q[0])) begin
            pend_fd_q <= own_q[0]; i_q <= '0; st_q <= S_EMIT;
          end else st_q <= S_STAT;
        end
        S_EMIT: begin
          if (out_free) st_q <= S_RMV;
        end
        S_RMV: begin
          // move the last entry into slot i, then sift it
          vld_q[AW'(own_q[i_q])] <= 1'b0;
          cnt_q <= cnt_q - CW'(1);
          if (i_q < last_sl) begin
            exp_q[i_q] <= exp_q[last_sl];
            own_q[i_q] <= own_q[last_sl];
            moved_q <= 1'b0;
            st_q <= S_DOWN;
          end else st_q <= done_st;
        end
        S_DOWN: begin
          if (down_go) begin
            exp_q[i_q] <= exp_q[cs]; own_q[i_q] <= own_q[cs];
            exp_q[cs]  <= exp_q[i_q]; own_q[cs] <= own_q[i_q];
            hold_fd_q <= own_q[i_q]; hold_sl_q <= cs;
            i_q <= cs; moved_q <= 1'b1;
            ret_q <= S_DOWN; st_q <= S_FIX;
          end else if (moved_q) begin
            st_q <= done_st;
          end else st_q <= S_UP;
        end
        S_UP: begin
          if (up_go) begin
            exp_q[i_q] <= exp_q[par]; own_q[i_q] <= own_q[par];
            exp_q[par] <= exp_q[i_q]; own_q[par] <= own_q[i_q];
            hold_fd_q <= own_q[i_q]; hold_sl_q <= par;
            i_q <= par;
            ret_q <= S_UP; st_q <= S_FIX;
          end else st_q <= done_st;
        end
        S_FIX: st_q <= ret_q;
        S_CLR: begin
          if (ci_q == cnt_q) begin
            cnt_q <= '0; st_q <= S_STAT;
          end else if (out_free) begin
            vld_q[AW'(own_q[SW'(ci_q)])] <= 1'b0;
            ci_q <= ci_q + CW'(1);
          end
        end
        S_STAT: begin
          if (out_free) st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/timer_min_heap_queue.sv
// Timer heap queue: one input item per action, 1..33 result items each. Each action passes
// from the two-entry front queue through the back end's dispatch, sift, fire and clear
// states to its closing status item; stalls on the output channel hold it there.
// One action is handled at a time; the front queue takes up to two more meanwhile.
// Reset: asynchronous active low; empties the queue, clears the clock and all fd entries.
`default_nettype none
module timer_min_heap_queue #(
  parameter int unsigned CAPACITY = 32,
  parameter int unsigned FD_SLOTS = 256
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  tmhq_in_if.sink    in_if,
  tmhq_out_if.source out_if
);
  logic           cmd_valid, cmd_pop;
  tmhq_pkg::cmd_t cmd;

  tmhq_front #(.FdSlots(FD_SLOTS)) u_front (
    .clk_i, .rst_ni, .in_if,
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_pop_i(cmd_pop)
  );

  tmhq_back #(.Capacity(CAPACITY), .FdSlots(FD_SLOTS)) u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_pop_o(cmd_pop), .out_if
  );
endmodule
`default_nettype wire

// File: verif/tmhq_checker.sv
// Checker for the timer heap queue: watches both channels, predicts the
// result items of each transfer and compares them. Depends on tmhq_pkg, tmhq_if.
`timescale 1ns / 1ps
module tmhq_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  tmhq_in_if  in_if,
  tmhq_out_if out_if,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  localparam int unsigned Cap   = 32;
  localparam int unsigned Slots = 256;
  localparam logic [31:0] WaitSat = 32'd16777215;

  typedef struct packed {
    logic                           fired;
    logic [tmhq_pkg::FdW-1:0]       fired_fd;
    logic [1:0]                     status;
    logic [tmhq_pkg::WaitW-1:0]     next_wait_ms;
    logic                           last;
  } result_t;

  logic [31:0]              tm_expiry [Cap];
  logic [tmhq_pkg::FdW-1:0] tm_owner [Cap];
  int unsigned              fd_slot [Slots];
  bit                       fd_held [Slots];
  int unsigned              tm_count;
  logic [31:0]              clock_ms;
  result_t                  expected_q[$];

  function automatic bit is_before(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31];
  endfunction

  function automatic void swap_entries(int unsigned i, int unsigned j);
    logic [31:0]              e;
    logic [tmhq_pkg::FdW-1:0] o;
    e = tm_expiry[i]; o = tm_owner[i];
    tm_expiry[i] = tm_expiry[j]; tm_owner[i] = tm_owner[j];
    tm_expiry[j] = e; tm_owner[j] = o;
    fd_slot[tm_owner[i]] = i;
    fd_slot[tm_owner[j]] = j;
  endfunction

  function automatic void bubble_up(int unsigned i);
    int unsigned p;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (is_before(tm_expiry[p], tm_expiry[i])) break;
      swap_entries(i, p);
      i = p;
    end
  endfunction

  function automatic bit bubble_down(int unsigned i, int unsigned n);
    int unsigned start, c;
    start = i;
    c = 2 * i + 1;
    while (c < n) begin
      if (c + 1 < n && is_before(tm_expiry[c+1], tm_expiry[c])) c++;
      if (is_before(tm_expiry[i], tm_expiry[c])) break;
      swap_entries(i, c);
      i = c;
      c = 2 * i + 1;
    end
    return i > start;
  endfunction

  function automatic void drop_entry(int unsigned i);
    int unsigned n;
    n = tm_count - 1;
    if (i < n) begin
      swap_entries(i, n);
      if (!bubble_down(i, n)) bubble_up(i);
    end
    fd_held[tm_owner[n]] = 0;
    tm_count = n;
  endfunction

  function automatic void add_expected(result_t r);
    expected_q.insert(expected_q.size(), r);
  endfunction

  function automatic void push_fired(logic [tmhq_pkg::FdW-1:0] fd);
    result_t r;
    r = '0;
    r.fired = 1'b1;
    r.fired_fd = fd;
    add_expected(r);
  endfunction

  function automatic void apply_action(tmhq_pkg::action_e act, logic [tmhq_pkg::FdW-1:0] fd,
                                       logic [tmhq_pkg::TimeoutW-1:0] tmo,
                                       logic [tmhq_pkg::ElapsedW-1:0] el);
    tmhq_pkg::status_e st;
    result_t           r;
    int unsigned       i;
    logic [31:0]       d;
    st = tmhq_pkg::ST_OK;
    case (act)
      tmhq_pkg::ACT_ADD, tmhq_pkg::ACT_REARM: begin
        if (fd_held[fd]) begin
          i = fd_slot[fd];
          tm_expiry[i] = clock_ms + 32'(tmo);
          if (!bubble_down(i, tm_count)) bubble_up(i);
        end else if (act == tmhq_pkg::ACT_REARM) begin
          st = tmhq_pkg::ST_ABSENT;
        end else if (tm_count >= Cap) begin
          st = tmhq_pkg::ST_FULL;
        end else begin
          i = tm_count;
          tm_expiry[i] = clock_ms + 32'(tmo);
          tm_owner[i] = fd;
          fd_slot[fd] = i;
          fd_held[fd] = 1;
          tm_count = i + 1;
          bubble_up(i);
        end
      end
      tmhq_pkg::ACT_FIRE: begin
        if (!fd_held[fd] || tm_count == 0) begin
          st = tmhq_pkg::ST_ABSENT;
        end else begin
          push_fired(fd);
          drop_entry(fd_slot[fd]);
        end
      end
      tmhq_pkg::ACT_ADV: begin
        clock_ms = clock_ms + 32'(el);
        while (tm_count > 0 && !is_before(clock_ms, tm_expiry[0])) begin
          push_fired(tm_owner[0]);
          drop_entry(0);
        end
      end
      tmhq_pkg::ACT_CLEAR: begin
        for (int unsigned k = 0; k < tm_count; k++) begin
          push_fired(tm_owner[k]);
          fd_held[tm_owner[k]] = 0;
        end
        tm_count = 0;
      end
      default: ;
    endcase
    r = '0;
    r.status = st;
    r.last = 1'b1;
    if (tm_count == 0) begin
      r.next_wait_ms = '1;
    end else begin
      d = tm_expiry[0] - clock_ms;
      if (d[31]) r.next_wait_ms = '0;
      else if (d > WaitSat) r.next_wait_ms = WaitSat[tmhq_pkg::WaitW-1:0];
      else r.next_wait_ms = d[tmhq_pkg::WaitW-1:0];
    end
    add_expected(r);
  endfunction

  assign pending_o = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got, want;
    if (!rst_ni) begin
      fail_count_o <= 0;
      tm_count = 0;
      clock_ms = '0;
      for (int k = 0; k < Slots; k++) begin
        fd_held[k] = 0;
        fd_slot[k] = 0;
      end
      expected_q.delete();
    end else begin
      if (out_if.valid && out_if.ready) begin
        got = {out_if.fired, out_if.fired_fd, out_if.status, out_if.next_wait_ms, out_if.last};
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch, expected fired=%0d fd=%0d st=%0d wait=%0d last=%0d,",
                     $time, want.fired, want.fired_fd, want.status,
                     $signed(want.next_wait_ms), want.last);
            $display("%0t:   actual fired=%0d fd=%0d st=%0d wait=%0d last=%0d",
                     $time, got.fired, got.fired_fd, got.status,
                     $signed(got.next_wait_ms), got.last);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_if.valid && in_if.ready)
        apply_action(tmhq_pkg::action_e'(in_if.action), in_if.fd, in_if.timeout_ms,
                     in_if.elapsed_ms);
    end
  end
endmodule

// File: verif/testbench.sv
// Top of the timer heap queue testbench: clock, reset, stimulus, output stall
// and verdict. Depends on tmhq_pkg, tmhq_if, tmhq_checker and the block.
`timescale 1ns / 1ps
module testbench;
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int unsigned fail_count, pending;
  bit quiet_phase = 0;

  tmhq_in_if  in_if ();
  tmhq_out_if out_if ();

  timer_min_heap_queue DUT (.clk_i(clk_i), .rst_ni(rst_ni), .in_if(in_if), .out_if(out_if));
  tmhq_checker checker_inst (.clk_i(clk_i), .rst_ni(rst_ni), .in_if(in_if), .out_if(out_if),
                             .fail_count_o(fail_count), .pending_o(pending));

  always #1 clk_i = ~clk_i;

  initial begin
    in_if.valid = 1'b0;
    in_if.action = '0;
    in_if.fd = '0;
    in_if.timeout_ms = '0;
    in_if.elapsed_ms = '0;
    out_if.ready = 1'b0;
  end

  // receiver: random stall bursts until the quiet phase
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 6);
        out_if.ready <= 1'b0;
        repeat (n - 1) @(posedge clk_i);
        @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
    end
  end

  task automatic send_item(tmhq_pkg::action_e act, logic [tmhq_pkg::FdW-1:0] fd,
                           logic [tmhq_pkg::TimeoutW-1:0] tmo,
                           logic [tmhq_pkg::ElapsedW-1:0] el);
    int n;
    if (!quiet_phase && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 6);
      in_if.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.action <= act;
    in_if.fd <= fd;
    in_if.timeout_ms <= tmo;
    in_if.elapsed_ms <= el;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic drain_all();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // small fd pool in the random part so re-arm, fire and fills hit present fds
  function automatic logic [tmhq_pkg::FdW-1:0] pick_fd();
    return ($urandom_range(0, 9) == 0) ? tmhq_pkg::FdW'($urandom) :
                                          tmhq_pkg::FdW'($urandom_range(0, 40));
  endfunction

  initial begin
    int r;
    tmhq_pkg::action_e act;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty-queue errors, extremes, ties, full queue, long timers
    send_item(tmhq_pkg::ACT_REARM, 8'd5, 24'd10, 16'd0);
    send_item(tmhq_pkg::ACT_FIRE, 8'd255, 24'd0, 16'd0);
    send_item(tmhq_pkg::ACT_ADD, 8'd255, 24'hFFFFFF, 16'd0);
    send_item(tmhq_pkg::ACT_ADD, 8'd0, 24'd0, 16'd0);
    send_item(tmhq_pkg::ACT_ADD, 8'd1, 24'd100, 16'd0);
    send_item(tmhq_pkg::ACT_ADD, 8'd2, 24'd100, 16'd0);
    send_item(tmhq_pkg::ACT_ADD, 8'd1, 24'd50, 16'd0);
    send_item(tmhq_pkg::ACT_REARM, 8'd2, 24'd5000, 16'd0);
    send_item(tmhq_pkg::ACT_FIRE, 8'd1, 24'd0, 16'd0);
    send_item(tmhq_pkg::ACT_ADV, 8'd0, 24'd0, 16'd100);
    send_item(tmhq_pkg::ACT_NOP5, 8'hAA, 24'h555555, 16'hAAAA);
    send_item(tmhq_pkg::ACT_NOP6, 8'h55, 24'hAAAAAA, 16'h5555);
    send_item(tmhq_pkg::ACT_NOP7, 8'd0, 24'd0, 16'd0);
    for (int k = 0; k < 33; k++)
      send_item(tmhq_pkg::ACT_ADD, 8'(100 + k), 24'(k * 7 % 5), 16'd0);
    send_item(tmhq_pkg::ACT_ADV, 8'd0, 24'd0, 16'hFFFF);
    send_item(tmhq_pkg::ACT_CLEAR, 8'd0, 24'd0, 16'd0);
    drain_all();
    // long timers, a clock advance that fires none of them, then more adds and a clear
    for (int k = 0; k < 3; k++) send_item(tmhq_pkg::ACT_ADD, 8'(k), 24'hFFFFFF, 16'd0);
    send_item(tmhq_pkg::ACT_ADV, 8'd0, 24'd0, 16'hFFFF);
    for (int k = 0; k < 8; k++)
      send_item(tmhq_pkg::ACT_ADD, 8'(k + 10), 24'(k * 1000), 16'd0);
    send_item(tmhq_pkg::ACT_CLEAR, 8'd0, 24'd0, 16'd0);
    drain_all();

    for (int k = 0; k < 310; k++) begin
      if (k == 270) begin
        drain_all();
        quiet_phase = 1;
      end
      r = $urandom_range(0, 99);
      if (r < 40) act = tmhq_pkg::ACT_ADD;
      else if (r < 55) act = tmhq_pkg::ACT_REARM;
      else if (r < 72) act = tmhq_pkg::ACT_FIRE;
      else if (r < 92) act = tmhq_pkg::ACT_ADV;
      else if (r < 96) act = tmhq_pkg::ACT_CLEAR;
      else act = tmhq_pkg::action_e'($urandom_range(5, 7));
      send_item(act, pick_fd(),
                ($urandom_range(0, 7) == 0) ? tmhq_pkg::TimeoutW'($urandom) :
                                              tmhq_pkg::TimeoutW'($urandom_range(0, 2000)),
                ($urandom_range(0, 7) == 0) ? tmhq_pkg::ElapsedW'($urandom) :
                                              tmhq_pkg::ElapsedW'($urandom_range(0, 300)));
    end
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end
endmodule

// File: files.f
hw/rtl/tmhq_pkg.sv
hw/rtl/tmhq_if.sv
hw/rtl/tmhq_ram.sv
hw/rtl/tmhq_front.sv
hw/rtl/tmhq_back.sv
hw/rtl/timer_min_heap_queue.sv
verif/tmhq_checker.sv
verif/testbench.sv
